/* src/cls_tok_pkg.sv */
// ---------------------------------------------------------------------------
// cls_tok_pkg: shared types and constants of the source tokenizer
// Token codes, scan modes and the keyword lookup used by the top level.
// ---------------------------------------------------------------------------
package cls_tok_pkg;

    localparam int POSITION_BITS_DEF   = 16;
    localparam int KEYWORD_MAX_LEN_DEF = 9;
    localparam int TYPE_BITS           = 7;
    localparam int OUT_BITS            = 16;
    localparam int KW_COUNT            = 27;

    localparam logic [6:0] T_STR   = 7'd27;
    localparam logic [6:0] T_CHR   = 7'd28;
    localparam logic [6:0] T_FLT   = 7'd29;
    localparam logic [6:0] T_INT   = 7'd30;
    localparam logic [6:0] T_IDENT = 7'd31;
    localparam logic [6:0] T_DOT   = 7'd66;
    localparam logic [6:0] T_EOF   = 7'd71;
    localparam logic [6:0] T_ERR   = 7'd72;
    localparam logic [6:0] T_NONE  = 7'd0;

    typedef enum logic [3:0] {
        M_NORMAL, M_OP, M_LCMT, M_BCMT, M_BSTAR, M_STR, M_STRESC, M_CHR0,
        M_CHR1, M_NINT, M_NDOT, M_NFRAC, M_IDENT
    } mode_t;

    // Keyword text, first character in the low byte, zero padded.
    typedef logic [8*9-1:0] kw_text_t;

    // Keyword length in bytes.
    function automatic logic [3:0] kw_len(input int k);
        case (k)
            0, 5, 9, 16: kw_len = 4'd3;
            2, 4, 7, 17, 18, 26: kw_len = 4'd4;
            1, 8, 13, 15, 25: kw_len = 4'd5;
            3, 12, 19, 22: kw_len = 4'd6;
            10, 20: kw_len = 4'd7;
            14, 23: kw_len = 4'd8;
            21: kw_len = 4'd9;
            6, 11: kw_len = 4'd2;
            24: kw_len = 4'd4;
            default: kw_len = 4'd0;
        endcase
    endfunction

    function automatic kw_text_t kw_text(input int k);
        kw_text_t raw;
        kw_text_t r;
        int       n;
        case (k)
            0:  raw = "int";
            1:  raw = "float";
            2:  raw = "bool";
            3:  raw = "string";
            4:  raw = "void";
            5:  raw = "var";
            6:  raw = "if";
            7:  raw = "else";
            8:  raw = "while";
            9:  raw = "for";
            10: raw = "foreach";
            11: raw = "in";
            12: raw = "return";
            13: raw = "break";
            14: raw = "continue";
            15: raw = "class";
            16: raw = "new";
            17: raw = "this";
            18: raw = "base";
            19: raw = "public";
            20: raw = "private";
            21: raw = "protected";
            22: raw = "static";
            23: raw = "override";
            24: raw = "true";
            25: raw = "false";
            26: raw = "null";
            default: raw = '0;
        endcase
        // A string literal holds its first character in the top byte; flip order
        n = int'(kw_len(k));
        r = '0;
        for (int i = 0; i < 9; i++) begin
            if (i < n) r[8*i +: 8] = raw[8*(n-1-i) +: 8];
        end
        kw_text = r;
    endfunction

    function automatic logic [6:0] op_single(input logic [7:0] c);
        case (c)
            "+": op_single = 7'd34;
            "-": op_single = 7'd38;
            "*": op_single = 7'd40;
            "/": op_single = 7'd42;
            "=": op_single = 7'd45;
            "!": op_single = 7'd47;
            "<": op_single = 7'd49;
            ">": op_single = 7'd51;
            "&": op_single = 7'd53;
            "|": op_single = 7'd55;
            default: op_single = 7'd68;
        endcase
    endfunction

    function automatic logic [6:0] op_pair(input logic [7:0] a, input logic [7:0] b);
        op_pair = T_NONE;
        case (a)
            "+": op_pair = (b == "+") ? 7'd32 : (b == "=") ? 7'd33 : T_NONE;
            "-": op_pair = (b == "-") ? 7'd35 : (b == "=") ? 7'd36 :
                           (b == ">") ? 7'd37 : T_NONE;
            "*": op_pair = (b == "=") ? 7'd39 : T_NONE;
            "/": op_pair = (b == "=") ? 7'd41 : T_NONE;
            "=": op_pair = (b == "=") ? 7'd44 : T_NONE;
            "!": op_pair = (b == "=") ? 7'd46 : T_NONE;
            "<": op_pair = (b == "=") ? 7'd48 : T_NONE;
            ">": op_pair = (b == "=") ? 7'd50 : T_NONE;
            "&": op_pair = (b == "&") ? 7'd52 : T_NONE;
            "|": op_pair = (b == "|") ? 7'd54 : T_NONE;
            ":": op_pair = (b == ":") ? 7'd67 : T_NONE;
            default: op_pair = T_NONE;
        endcase
    endfunction

    function automatic logic [6:0] single_type(input logic [7:0] c);
        case (c)
            "%": single_type = 7'd43;
            "^": single_type = 7'd56;
            "~": single_type = 7'd57;
            "(": single_type = 7'd58;
            ")": single_type = 7'd59;
            "{": single_type = 7'd60;
            "}": single_type = 7'd61;
            "[": single_type = 7'd62;
            "]": single_type = 7'd63;
            ";": single_type = 7'd64;
            ",": single_type = 7'd65;
            ".": single_type = 7'd66;
            "?": single_type = 7'd69;
            "@": single_type = 7'd70;
            default: single_type = T_NONE;
        endcase
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    // One token transaction.
    typedef struct packed {
        logic [6:0]  ttype;
        logic [15:0] line;
        logic [15:0] start;
        logic [15:0] length;
    } tok_t;

endpackage

/* src/c_like_source_tokenizer.sv */
// ---------------------------------------------------------------------------
// c_like_source_tokenizer: streaming lexer for a C-like language
// Turns a byte stream into typed tokens with line, offset and length.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one transaction is a source byte (ch)
//   or an end marker (is_end=1). Output channel (out_valid/out_stall): one
//   transaction is a token; last_of_run marks the final token caused by an
//   input transaction.
//   Throughput is one input byte per cycle while in_stall is low. A byte
//   produces zero to three tokens (a number, its dot and a punctuation
//   byte), the end marker up to three. The scan logic builds all tokens of
//   a byte at once into a small output queue (depth 4); tokens leave at one
//   per cycle while out_stall is low, so a byte that yields more than one
//   token can hold the input. A byte's tokens are queued in the cycle after it is taken.
//   in_stall rises only when the queue cannot take a worst case burst.
//   A stalled output holds its token stable.
//   Reset (rst_n low, asynchronous) clears counters to offset 0, line 1,
//   empties the queue and returns to normal scanning. The end marker resets
//   offset, line and scan mode (not the queue) after flushing the pending token and end-of-file.
// ---------------------------------------------------------------------------
module c_like_source_tokenizer
    import cls_tok_pkg::*;
#(
    parameter int POSITION_BITS   = POSITION_BITS_DEF,
    parameter int KEYWORD_MAX_LEN = KEYWORD_MAX_LEN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  ch,
    input  logic        is_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  token_type,
    output logic [15:0] token_line,
    output logic [15:0] token_start,
    output logic [15:0] token_length,
    output logic        last_of_run
);

    localparam int LW = $clog2(KEYWORD_MAX_LEN + 2);
    localparam int PB = POSITION_BITS;
    localparam logic [PB-1:0] POS_MAX = '1;
    localparam int QD = 4;

    typedef struct packed {
        tok_t tok;
        logic last;
    } qent_t;

    mode_t                        mode_reg, mode_next;
    logic [PB-1:0]                pos_reg;
    logic [15:0]                  line_reg;
    logic [PB-1:0]                begin_reg, begin_next;
    logic [7:0]                   opc_reg, opc_next;
    logic [8*KEYWORD_MAX_LEN-1:0] word_reg, word_next;
    logic [LW-1:0]                wlen_reg, wlen_next;

    qent_t      q_reg [QD];
    logic [1:0] rd_reg, wr_reg;
    logic [2:0] cnt_reg;

    logic       acc;
    logic [PB-1:0] idx, nxt, dot;
    logic [15:0] ln_new;
    logic [6:0] wtype, styp, pair;
    tok_t       e [3];
    logic [1:0] ne;
    logic       again;
    logic [1:0] pop;

    cls_tok_kw #(.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)) u_kw (
        .word      (word_reg),
        .word_len  (wlen_reg),
        .word_type (wtype)
    );

    assign in_stall = (cnt_reg > 3'd1);
    assign acc      = in_valid && !in_stall;
    assign idx      = pos_reg;
    assign nxt      = (pos_reg != POS_MAX) ? pos_reg + 1'b1 : pos_reg;
    assign dot      = (pos_reg != '0) ? pos_reg - 1'b1 : pos_reg;
    assign ln_new   = (ch == 8'h0A && line_reg != 16'hFFFF) ? line_reg + 1'b1 : line_reg;
    assign styp     = single_type(ch);
    assign pair     = op_pair(opc_reg, ch);

    function automatic tok_t mk(input logic [6:0] t, input logic [PB-1:0] b,
                                input logic [PB-1:0] en, input logic [15:0] l);
        tok_t r;
        logic [PB-1:0] d;
        d = en - b;
        r.ttype  = t;
        r.line   = l;
        r.start  = 16'(b);
        r.length = 16'(d);
        return r;
    endfunction

    // Scan logic: next state and tokens for one input transaction
    always_comb
    begin
        mode_next  = mode_reg;
        begin_next = begin_reg;
        opc_next   = opc_reg;
        word_next  = word_reg;
        wlen_next  = wlen_reg;
        ne         = 2'd0;
        again      = 1'b0;
        e[0] = '0; e[1] = '0; e[2] = '0;
        if (is_end) begin
            case (mode_reg)
                M_OP: begin e[0] = mk(op_single(opc_reg), begin_reg, idx, line_reg); ne = 2'd1; end
                M_STR, M_STRESC: begin e[0] = mk(T_STR, begin_reg, idx, line_reg); ne = 2'd1; end
                M_CHR0, M_CHR1: begin e[0] = mk(T_CHR, begin_reg, idx, line_reg); ne = 2'd1; end
                M_NINT: begin e[0] = mk(T_INT, begin_reg, idx, line_reg); ne = 2'd1; end
                M_NFRAC: begin e[0] = mk(T_FLT, begin_reg, idx, line_reg); ne = 2'd1; end
                M_NDOT:
                begin
                    e[0] = mk(T_INT, begin_reg, dot, line_reg);
                    e[1] = mk(T_DOT, dot, idx, line_reg);
                    ne = 2'd2;
                end
                M_IDENT: begin e[0] = mk(wtype, begin_reg, idx, line_reg); ne = 2'd1; end
                default: ne = 2'd0;
            endcase
            e[ne] = mk(T_EOF, idx, idx, line_reg);
            mode_next  = M_NORMAL;
            begin_next = '0;
            opc_next   = '0;
            word_next  = '0;
            wlen_next  = '0;
        end else begin
            case (mode_reg)
                M_OP:
                begin
                    if (opc_reg == "/" && ch == "/") mode_next = M_LCMT;
                    else if (opc_reg == "/" && ch == "*") mode_next = M_BCMT;
                    else if (pair != T_NONE) begin
                        e[0] = mk(pair, begin_reg, nxt, ln_new); ne = 2'd1;
                        mode_next = M_NORMAL;
                    end else begin
                        e[0] = mk(op_single(opc_reg), begin_reg, idx, line_reg); ne = 2'd1;
                        again = 1'b1;
                    end
                end
                M_LCMT: if (ch == 8'h0A) mode_next = M_NORMAL;
                M_BCMT: if (ch == "*") mode_next = M_BSTAR;
                M_BSTAR:
                begin
                    if (ch == "/") mode_next = M_NORMAL;
                    else if (ch != "*") mode_next = M_BCMT;
                end
                M_STR:
                begin
                    if (ch == "\"") begin
                        e[0] = mk(T_STR, begin_reg, nxt, ln_new); ne = 2'd1;
                        mode_next = M_NORMAL;
                    end else if (ch == "\\") mode_next = M_STRESC;
                end
                M_STRESC: mode_next = M_STR;
                M_CHR0:
                begin
                    if (ch == "'") begin
                        e[0] = mk(T_CHR, begin_reg, nxt, ln_new); ne = 2'd1;
                        mode_next = M_NORMAL;
                    end else mode_next = M_CHR1;
                end
                M_CHR1:
                begin
                    if (ch == "'") begin
                        e[0] = mk(T_CHR, begin_reg, nxt, ln_new); ne = 2'd1;
                        mode_next = M_NORMAL;
                    end else begin
                        e[0] = mk(T_CHR, begin_reg, idx, line_reg); ne = 2'd1;
                        again = 1'b1;
                    end
                end
                M_NINT, M_NFRAC:
                begin
                    if (is_digit(ch)) mode_next = mode_reg;
                    else if (ch == "." && mode_reg == M_NINT) mode_next = M_NDOT;
                    else if (ch == "f" || ch == "F") begin
                        e[0] = mk(T_FLT, begin_reg, nxt, ln_new); ne = 2'd1;
                        mode_next = M_NORMAL;
                    end else begin
                        e[0] = mk((mode_reg == M_NINT) ? T_INT : T_FLT,
                                  begin_reg, idx, line_reg);
                        ne = 2'd1;
                        again = 1'b1;
                    end
                end
                M_NDOT:
                begin
                    if (is_digit(ch)) mode_next = M_NFRAC;
                    else begin
                        e[0] = mk(T_INT, begin_reg, dot, line_reg);
                        e[1] = mk(T_DOT, dot, idx, line_reg);
                        ne = 2'd2;
                        again = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    if (is_alpha(ch) || is_digit(ch) || ch == "_") begin
                        if (wlen_reg < LW'(KEYWORD_MAX_LEN)) begin
                            word_next[8*wlen_reg[LW-1:0] +: 8] = ch;
                            wlen_next = wlen_reg + 1'b1;
                        end else wlen_next = LW'(KEYWORD_MAX_LEN + 1);
                    end else begin
                        e[0] = mk(wtype, begin_reg, idx, line_reg); ne = 2'd1;
                        again = 1'b1;
                    end
                end
                default: again = 1'b1;
            endcase
            // Start a new token from this byte
            if (again) begin
                mode_next  = M_NORMAL;
                begin_next = idx;
                if (ch == " " || ch == 8'h09 || ch == 8'h0D || ch == 8'h0A) ;
                else if (ch == "\"") mode_next = M_STR;
                else if (ch == "'") mode_next = M_CHR0;
                else if (is_digit(ch)) mode_next = M_NINT;
                else if (is_alpha(ch) || ch == "_") begin
                    mode_next = M_IDENT;
                    word_next = '0;
                    word_next[7:0] = ch;
                    wlen_next = LW'(1);
                end else if (ch == "+" || ch == "-" || ch == "*" || ch == "/" ||
                             ch == "=" || ch == "!" || ch == "<" || ch == ">" ||
                             ch == "&" || ch == "|" || ch == ":") begin
                    mode_next = M_OP;
                    opc_next  = ch;
                end else begin
                    e[ne] = mk((styp != T_NONE) ? styp : T_ERR, idx, nxt, ln_new);
                    ne = ne + 1'b1;
                end
            end
        end
    end

    // Scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= M_NORMAL;
            pos_reg   <= '0;
            line_reg  <= 16'd1;
            begin_reg <= '0;
            opc_reg   <= '0;
            word_reg  <= '0;
            wlen_reg  <= '0;
        end else if (acc) begin
            mode_reg  <= mode_next;
            begin_reg <= begin_next;
            opc_reg   <= opc_next;
            word_reg  <= word_next;
            wlen_reg  <= wlen_next;
            pos_reg   <= is_end ? '0 : nxt;
            line_reg  <= is_end ? 16'd1 : ln_new;
        end
    end

    // Output queue
    logic [1:0] nw;
    assign nw  = (acc) ? (is_end ? ne + 2'd1 : ne) : 2'd0;
    assign pop = (out_valid && !out_stall) ? 2'd1 : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            rd_reg  <= rd_reg + pop;
            wr_reg  <= wr_reg + nw;
            cnt_reg <= cnt_reg + 3'(nw) - 3'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < nw) begin
                q_reg[wr_reg + 2'(i)].tok  <= e[i];
                q_reg[wr_reg + 2'(i)].last <= (2'(i) == nw - 2'd1);
            end
        end
    end

    assign out_valid    = (cnt_reg != 3'd0);
    assign token_type   = q_reg[rd_reg].tok.ttype;
    assign token_line   = q_reg[rd_reg].tok.line;
    assign token_start  = q_reg[rd_reg].tok.start;
    assign token_length = q_reg[rd_reg].tok.length;
    assign last_of_run  = q_reg[rd_reg].last;

endmodule

/* src/cls_tok_kw.sv */
// ---------------------------------------------------------------------------
// cls_tok_kw: keyword matcher
// Compares the buffered word against all keywords in parallel.
// ---------------------------------------------------------------------------
module cls_tok_kw
    import cls_tok_pkg::*;
#(
    parameter int KEYWORD_MAX_LEN = KEYWORD_MAX_LEN_DEF
)
(
    input  logic [8*KEYWORD_MAX_LEN-1:0]     word,
    input  logic [$clog2(KEYWORD_MAX_LEN+2)-1:0] word_len,
    output logic [6:0]                       word_type
);

    localparam int LW = $clog2(KEYWORD_MAX_LEN + 2);

    // Parallel compare; buffer is zero past the word so a full compare works
    always_comb
    begin
        word_type = T_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if ((word_len == LW'(kw_len(k))) &&
                (word == (8*KEYWORD_MAX_LEN)'(kw_text(k))))
                word_type = 7'(k);
        end
    end

endmodule

/* src/cls_tok_chk.sv */
// ---------------------------------------------------------------------------
// cls_tok_chk: port checker for the tokenizer
// Watches the top level's ports and flags protocol and ordering slips.
// ---------------------------------------------------------------------------
module cls_tok_chk
    import cls_tok_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [6:0]  token_type,
    input logic [15:0] token_line,
    input logic        last_of_run
);

    // Stalled token holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(token_type) && $stable(token_line))
        else $error("stalled token changed");

    // End-of-file always closes its run
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_type == T_EOF |-> last_of_run)
        else $error("eof without last_of_run");

    // Line numbers never zero
    a_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_line != 16'd0)
        else $error("zero line number");

    // Input is held off only while tokens are queued
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty queue");

    // Nothing leaves without input first after reset
    a_rst: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("token right after reset");

endmodule

bind c_like_source_tokenizer cls_tok_chk u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .token_type  (token_type),
    .token_line  (token_line),
    .last_of_run (last_of_run)
);
